>>> sv/crc32bs_pkg.sv
// crc32bs_pkg: shared types and the CRC table function for crc32_byte_stream.
// No dependencies.
package crc32bs_pkg;

  localparam logic [31:0] CrcPoly    = 32'h04C1_1DB7;
  localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;
  localparam int unsigned HeadBytes  = 4;
  localparam int unsigned SeenW      = 3;

  // Running checksum state
  typedef struct packed {
    logic [31:0]      crc;
    logic [SeenW-1:0] seen;
  } crc_state_t;

  localparam crc_state_t StateInit = '{crc: CrcInit, seen: '0};

  // MSB-first table entry for one byte: a fixed XOR network after synthesis
  function automatic logic [31:0] table_entry(input logic [7:0] idx);
    logic [31:0] acc;
    acc = {idx, 24'h00_0000};
    for (int b = 0; b < 8; b++) begin
      if (acc[31]) begin
        acc = {acc[30:0], 1'b0} ^ CrcPoly;
      end else begin
        acc = {acc[30:0], 1'b0};
      end
    end
    return acc;
  endfunction

endpackage

>>> sv/crc32_byte_stream.sv
// crc32_byte_stream: byte-serial checksum (poly 0x04C11DB7, MSB first, no augmentation).
// Uses crc32bs_pkg, crc32bs_step, crc32bs_out_reg.
//
//  channel | valid      | ready      | payload
//  --------+------------+------------+--------------------------
//  in      | in_valid_i | in_ready_o | data_byte_i, last_byte_i
//  out     | out_valid_o| out_ready_i| checksum_o
//
// One item per cycle sustained while no last item is held back. An item is captured
// into the input register, then folded into the running state once it advances; a
// last-marked item loads the result register, which drives checksum_o.
// Reset clears the running state to all ones with zero bytes seen.
// A last item waits in the input register while the result register is full
// and not being taken; non-last items never wait on the output side.
module crc32_byte_stream (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] checksum_o
);

  // Input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       last_q;

  // Running state
  crc32bs_pkg::crc_state_t state_q, state_d, state_next;

  logic advance;   // item in input register is consumed this cycle
  logic emit;      // it is a last item: load the result register

  // A last item needs a free (or draining) result slot
  assign advance    = in_valid_q & (~last_q | ~out_valid_o | out_ready_i);
  assign emit       = advance & last_q;
  assign in_ready_o = ~in_valid_q | advance;
  assign in_valid_d = (in_valid_i & in_ready_o) | (in_valid_q & ~advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  crc32bs_step u_step (
    .state_i     (state_q),
    .data_byte_i (byte_q),
    .state_o     (state_next)
  );

  // Message end returns the state to its reset value
  always_comb begin
    if (emit) begin
      state_d = crc32bs_pkg::StateInit;
    end else if (advance) begin
      state_d = state_next;
    end else begin
      state_d = state_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crc32bs_pkg::StateInit;
    end else begin
      state_q <= state_d;
    end
  end

  crc32bs_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (emit),
    .checksum_d_i (~state_next.crc),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .checksum_o   (checksum_o)
  );

  // Byte count saturates at the head length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.seen <= 3'(crc32bs_pkg::HeadBytes))
    else $error("bytes seen past saturation");

  // A finished message leaves the state at reset value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (state_q.crc == crc32bs_pkg::CrcInit) && (state_q.seen == '0))
    else $error("state not cleared after message end");

  // A held item keeps its byte and does not change the state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q && $stable(byte_q) && $stable(state_q))
    else $error("held item lost or state moved");

  // Emitting always produces a valid result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o)
    else $error("result not presented");

endmodule

>>> sv/crc32bs_step.sv
// crc32bs_step: next checksum state for one byte.
// Uses crc32bs_pkg (state type, table function).
module crc32bs_step (
  input  crc32bs_pkg::crc_state_t state_i,
  input  logic [7:0]              data_byte_i,
  output crc32bs_pkg::crc_state_t state_o
);

  logic [31:0] head_mask;

  // Head bytes land from the top byte down
  always_comb begin
    unique case (state_i.seen[1:0])
      2'd0:    head_mask = {data_byte_i, 24'h00_0000};
      2'd1:    head_mask = {8'h00, data_byte_i, 16'h0000};
      2'd2:    head_mask = {16'h0000, data_byte_i, 8'h00};
      default: head_mask = {24'h00_0000, data_byte_i};
    endcase
  end

  always_comb begin
    if (!state_i.seen[2]) begin
      state_o.crc  = state_i.crc ^ head_mask;
      state_o.seen = state_i.seen + crc32bs_pkg::SeenW'(1);
    end else begin
      state_o.crc  = {state_i.crc[23:0], data_byte_i}
                     ^ crc32bs_pkg::table_entry(state_i.crc[31:24]);
      state_o.seen = state_i.seen;
    end
  end

endmodule

>>> sv/crc32bs_out_reg.sv
// crc32bs_out_reg: result register holding one finished checksum.
// Uses no package items.
module crc32bs_out_reg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [31:0] checksum_d_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [31:0] checksum_o
);

  logic        valid_q, valid_d;
  logic [31:0] checksum_q;

  // load is only raised when the slot is empty or drains this cycle
  assign valid_d = load_i | (valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      checksum_q <= checksum_d_i;
    end
  end

  assign out_valid_o = valid_q;
  assign checksum_o  = checksum_q;

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench for crc32_byte_stream. A queue-fed driver with bursts and gaps,
// a result monitor with a table-driven checksum predictor, and a watchdog.
// Depends on crc32bs_pkg and crc32_byte_stream only.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned RandomItems   = 900;
  localparam int unsigned HoldCycles    = 400;   // one long receiver hold-off
  localparam int unsigned HoldAfter     = 40;    // checksums seen before the hold-off
  localparam int unsigned WatchdogLimit = 4000;  // cycles with no handshake on either side
  localparam int unsigned SettleCycles  = 20;    // quiet time after the last checksum

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_HALF,
    RX_SPARSE,
    RX_BUSY
  } rx_mode_e;

  // One pending input item; drain holds it back until every checksum is out
  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain;
  } stream_item_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] checksum_o;

  stream_item_t item_q[$];
  stream_item_t next_item;
  logic [31:0]  checksum_q[$];   // checksums still owed by the block

  // Predictor state: running register and head-byte count
  logic [31:0]  crc_table [256];
  logic [31:0]  run_crc;
  int unsigned  run_seen;

  int unsigned  pending_sums   = 0;  // registered copy of checksum_q.size()
  int unsigned  sums_seen      = 0;
  int unsigned  errors         = 0;
  int unsigned  burst_left     = 0;
  int unsigned  gap_left       = 0;
  int unsigned  hold_left      = 0;
  bit           hold_done      = 1'b0;
  int unsigned  mode_timer     = 0;
  rx_mode_e     rx_mode        = RX_ALWAYS;
  int unsigned  quiet_cycles   = 0;

  crc32_byte_stream DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .checksum_o  (checksum_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Divisor table, built bit by bit: entry i is the remainder of i followed by 32 zero bits.
  initial begin
    logic [31:0] rem;
    for (int i = 0; i < 256; i++) begin
      rem = 32'(i) << 24;
      for (int k = 0; k < 8; k++) begin
        rem = rem[31] ? ((rem << 1) ^ crc32bs_pkg::CrcPoly) : (rem << 1);
      end
      crc_table[i] = rem;
    end
  end

  // Folds one byte into the predicted register. Returns 1 when the byte closes a message,
  // with the inverted register queued as the expected checksum.
  function automatic bit fold_byte(input logic [7:0] data, input logic last);
    int unsigned shift;
    if (run_seen < crc32bs_pkg::HeadBytes) begin
      // head bytes land from bits 31..24 downward, no table lookup yet
      shift   = 24 - 8 * run_seen;
      run_crc = run_crc ^ (32'(data) << shift);
      run_seen++;
    end else begin
      run_crc = {run_crc[23:0], data} ^ crc_table[run_crc[31:24]];
    end
    if (last) begin
      checksum_q.push_back(~run_crc);
      run_crc  = crc32bs_pkg::CrcInit;
      run_seen = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void add_item(input logic [7:0] data, input logic last, input bit drain);
    stream_item_t it;
    it.data  = data;
    it.last  = last;
    it.drain = drain;
    item_q.push_back(it);
  endfunction

  // Stimulus and end of run
  initial begin
    logic [7:0]  dir_bytes [23];
    int unsigned dir_lens  [7];
    int unsigned pos;
    int unsigned len;
    int unsigned sel;

    // Directed: single bytes at both extremes, short messages of two and three bytes
    // (packed result), exactly four head bytes, the first byte past the head (first
    // table lookup), a longer message, and an all-ones head.
    dir_bytes = '{8'h00,
                  8'hFF,
                  8'hA5, 8'h5A,
                  8'h01, 8'h80, 8'hFF,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'h00, 8'h00, 8'h00, 8'h00, 8'hFF,
                  8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE};
    dir_lens  = '{1, 1, 2, 3, 4, 5, 7};
    pos = 0;
    foreach (dir_lens[m]) begin
      for (int b = 0; b < dir_lens[m]; b++) begin
        add_item(dir_bytes[pos], b == dir_lens[m] - 1, 1'b0);
        pos++;
      end
    end

    // Random messages: mostly short so checksums come often, some long runs
    // through the table path. The first one waits for a fully drained block.
    for (int n = 0; n < RandomItems; n += len) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        len = $urandom_range(1, 6);
      end else if (sel < 95) begin
        len = $urandom_range(7, 20);
      end else begin
        len = $urandom_range(21, 64);
      end
      for (int b = 0; b < len; b++) begin
        add_item(8'($urandom_range(0, 255)), b == len - 1,
                 b == 0 && (n == 0 || $urandom_range(0, 24) == 0));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // All items sent and every checksum out (checked between edges, after the
    // driver and monitor have settled), then a quiet tail for stray results
    while (item_q.size() != 0 || in_valid_i || pending_sums != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (checksum_q.size() != 0) begin
      $display("%0t: %0d checksum(s) never arrived", $time, checksum_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Driver: bursts of random length separated by random gaps. Valid is only
  // changed when no item is on the wire or the current one is taken this edge.
  // A drain item first drops valid so that the last accepted item is already
  // counted in pending_sums, then waits for it to reach zero.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= $urandom_range(1, 32);
      gap_left   <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (item_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (item_q[0].drain && (in_valid_i || pending_sums != 0)) begin
        in_valid_i <= 1'b0;
      end else begin
        next_item   = item_q.pop_front();
        in_valid_i  <= 1'b1;
        data_byte_i <= next_item.data;
        last_byte_i <= next_item.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 32);
          // a third of bursts run straight into the next one
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: a stall pattern redrawn at random as mode_timer runs, plus one long
  // hold-off once a few dozen checksums have passed. During the hold-off the
  // sender keeps going, so a closing byte parks in the block and stalls input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
      mode_timer  <= 0;
      rx_mode     <= RX_ALWAYS;
    end else begin
      mode_timer <= mode_timer + 1;
      if (mode_timer % 64 == 63) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left   <= hold_left - 1;
      end else if (!hold_done && sums_seen >= HoldAfter) begin
        out_ready_i <= 1'b0;
        hold_left   <= HoldCycles;
        hold_done   <= 1'b1;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_ready_i <= 1'b1;
          RX_HALF:   out_ready_i <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:   out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Monitor: checks the taken checksum against the oldest expected one first,
  // then folds the accepted byte into the predictor. Both sample pre-edge values.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    if (!rst_ni) begin
      run_crc      = crc32bs_pkg::CrcInit;
      run_seen     = 0;
      pending_sums <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (checksum_q.size() == 0) begin
          $display("%0t: checksum 0x%08h with none expected", $time, checksum_o);
          errors++;
        end else begin
          want = checksum_q.pop_front();
          if (checksum_o !== want) begin
            $display("%0t: checksum expected 0x%08h actual 0x%08h", $time, want, checksum_o);
            errors++;
          end
        end
        sums_seen <= sums_seen + 1;
      end
      if (in_valid_i && in_ready_o) begin
        void'(fold_byte(data_byte_i, last_byte_i));
      end
      pending_sums <= checksum_q.size();
    end
  end

  // Watchdog: no handshake on either channel for too long ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
